// ===== rtl/tka_pkg.sv =====
package tka_pkg;

	localparam int FUNC_W    = 2;
	localparam int KEY_W     = 8;
	localparam int THREAD_W  = 4;
	localparam int VALUE_W   = 64;
	localparam int STATUS_W  = 2;
	localparam int GRANT_W   = 7;

	localparam int KEY_COUNT_DEF    = 128;
	localparam int THREAD_COUNT_DEF = 16;

	// thread_id can only name this many value slots per key
	localparam int THREAD_SLOTS_MAX = 2 ** THREAD_W;

	// free-key search works in groups of this many keys
	localparam int GROUP_W    = 4;
	localparam int GROUP_SIZE = 2 ** GROUP_W;

	localparam logic [FUNC_W-1:0] FN_CREATE = 2'd0;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
	localparam logic [FUNC_W-1:0] FN_SET    = 2'd2;
	localparam logic [FUNC_W-1:0] FN_GET    = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [KEY_W-1:0]    key_index;
		logic [THREAD_W-1:0] thread_id;
		logic [VALUE_W-1:0]  value_in;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GRANT_W-1:0]  granted_key;
		logic [VALUE_W-1:0]  value_out;
	} rsp_t;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic clear;
		logic accept;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic out_free;
	} stat_t;

endpackage

// ===== rtl/tls_key_allocator.sv =====
// per-thread key store: create grants the lowest free key, delete frees it,
// set and get write and read a 64-bit value per key and thread. the accept
// cycle registers the request, starts the value ram read and registers the
// per-group free-key summary; the lookup state picks the lowest free group,
// forms the result and, once the output register is free, applies the
// update. the next request is taken right after, while the previous result
// may still sit in the output register. after reset in_ready stays low for
// a sweep that zeroes all KEY_COUNT * min(THREAD_COUNT, 16) value ram words
// (2048 at the defaults). deleting a key leaves its stored values in place
module tls_key_allocator
	import tka_pkg::*;
#(
	parameter int KEY_COUNT    = KEY_COUNT_DEF,
	parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);

	cmd_t  cmd;
	stat_t stat;

	// sequencing: clearing sweep, idle, lookup/finish
	tka_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// key map, free-key search, value ram and output register
	tka_dpath #(
		.KEY_COUNT    (KEY_COUNT),
		.THREAD_COUNT (THREAD_COUNT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/tka_ram.sv =====
module tka_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/tka_ctrl.sv =====
module tka_ctrl
	import tka_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (stat.clear_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				if (stat.out_free) begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.clear  = 1'b0;
		cmd.accept = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
			end
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			S_LOOK: begin
				cmd.finish = stat.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ===== rtl/tka_dpath.sv =====
module tka_dpath
	import tka_pkg::*;
#(
	parameter int KEY_COUNT    = KEY_COUNT_DEF,
	parameter int THREAD_COUNT = THREAD_COUNT_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  in_data,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  out_valid,
	input  logic  out_ready,
	output rsp_t  out_data
);

	localparam int TSLOTS  = (THREAD_COUNT < THREAD_SLOTS_MAX) ? THREAD_COUNT : THREAD_SLOTS_MAX;
	localparam int DEPTH   = KEY_COUNT * TSLOTS;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int NGROUPS = (KEY_COUNT + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int PAD_N   = 2 ** KEY_W;

	logic [KEY_COUNT-1:0] key_map_q;
	logic [PAD_N-1:0]     map_pad;

	logic [ADDR_W-1:0]    clr_addr_q;

	req_t                 req_q;
	logic [ADDR_W-1:0]    req_addr_q;

	logic [NGROUPS-1:0]   grp_free_s1;
	logic [GROUP_W-1:0]   grp_off_s1 [NGROUPS];
	logic [NGROUPS-1:0]   grp_free;
	logic [GROUP_W-1:0]   grp_off [NGROUPS];

	logic                 found;
	logic [KEY_W-1:0]     grant;

	logic [15:0]          addr_full;
	logic [ADDR_W-1:0]    in_addr;

	logic                 key_ok;
	logic                 thr_ok;
	logic                 ok;
	rsp_t                 rsp;

	logic                 ram_we;
	logic [ADDR_W-1:0]    ram_waddr;
	logic [VALUE_W-1:0]   ram_wdata;
	logic [VALUE_W-1:0]   ram_rdata;

	rsp_t                 out_q;
	logic                 out_valid_q;

	// key map padded to the full key_index range, keys past the count look used
	always_comb begin
		map_pad = '1;
		for (int k = 0; k < KEY_COUNT; k++) begin
			map_pad[k] = key_map_q[k];
		end
	end

	// first level of the free-key search: lowest free key in each group
	always_comb begin
		for (int g = 0; g < NGROUPS; g++) begin
			grp_free[g] = 1'b0;
			grp_off[g]  = '0;
			for (int b = GROUP_SIZE - 1; b >= 0; b--) begin
				if (!map_pad[g * GROUP_SIZE + b]) begin
					grp_free[g] = 1'b1;
					grp_off[g]  = GROUP_W'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			grp_free_s1 <= grp_free;
			for (int g = 0; g < NGROUPS; g++) begin
				grp_off_s1[g] <= grp_off[g];
			end
		end
	end

	// second level: lowest group holding a free key
	always_comb begin
		found = 1'b0;
		grant = '0;
		for (int g = NGROUPS - 1; g >= 0; g--) begin
			if (grp_free_s1[g]) begin
				found = 1'b1;
				grant = KEY_W'(g * GROUP_SIZE) + KEY_W'(grp_off_s1[g]);
			end
		end
	end

	// value slot of the incoming request, forced to zero when out of range
	always_comb begin
		addr_full = 16'(in_data.key_index) * 16'(TSLOTS) + 16'(in_data.thread_id);
		if ((32'(in_data.key_index) < 32'(KEY_COUNT))
				&& (32'(in_data.thread_id) < 32'(TSLOTS))) begin
			in_addr = addr_full[ADDR_W-1:0];
		end else begin
			in_addr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q      <= in_data;
			req_addr_q <= in_addr;
		end
	end

	// request evaluation
	always_comb begin
		key_ok = (32'(req_q.key_index) < 32'(KEY_COUNT)) && map_pad[req_q.key_index];
		thr_ok = 32'(req_q.thread_id) < 32'(THREAD_COUNT);
		ok     = 1'b0;
		rsp    = '0;
		case (req_q.func)
			FN_CREATE: begin
				ok = found;
				if (found) begin
					rsp.status      = ST_OK;
					rsp.granted_key = grant[GRANT_W-1:0];
				end else begin
					rsp.status = ST_FULL;
				end
			end
			FN_DELETE: begin
				ok         = key_ok;
				rsp.status = key_ok ? ST_OK : ST_INVALID;
			end
			FN_SET: begin
				ok         = key_ok && thr_ok;
				rsp.status = ok ? ST_OK : ST_INVALID;
			end
			FN_GET: begin
				ok         = key_ok && thr_ok;
				rsp.status = ok ? ST_OK : ST_INVALID;
				if (ok) begin
					rsp.value_out = ram_rdata;
				end
			end
			default: begin
				rsp.status = ST_INVALID;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_map_q <= '0;
		end else if (cmd.finish && ok) begin
			for (int k = 0; k < KEY_COUNT; k++) begin
				if ((req_q.func == FN_CREATE) && (grant == KEY_W'(k))) begin
					key_map_q[k] <= 1'b1;
				end
				if ((req_q.func == FN_DELETE) && (req_q.key_index == KEY_W'(k))) begin
					key_map_q[k] <= 1'b0;
				end
			end
		end
	end

	// clearing sweep after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign stat.clear_last = (32'(clr_addr_q) == 32'(DEPTH - 1));
	assign stat.out_free   = !out_valid_q || out_ready;

	always_comb begin
		ram_we    = cmd.clear || (cmd.finish && ok && (req_q.func == FN_SET));
		ram_waddr = cmd.clear ? clr_addr_q : req_addr_q;
		ram_wdata = cmd.clear ? '0 : req_q.value_in;
	end

	tka_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.accept),
		.raddr (in_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q <= rsp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
